// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the tape rasteriser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PTR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define PTR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PTR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define PTR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define PTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/ptr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptr_pkg
// Types, geometry constants and the pixel map for the tape row rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

   localparam int CELL_PITCH   = 100;
   localparam int HALF_PITCH   = CELL_PITCH / 2;
   localparam int LEFT_MARGIN  = 42;
   localparam int RIGHT_FIVE   = 45;
   localparam int RIGHT_EIGHT  = 58;
   localparam int BITS_FIVE    = 5;
   localparam int BITS_EIGHT   = 8;
   localparam int DATA_R2      = 1296;
   localparam int SPROCKET_R2  = 529;

   localparam int WIDTH_FIVE   = LEFT_MARGIN + CELL_PITCH * (BITS_FIVE + 1) + RIGHT_FIVE;
   localparam int WIDTH_EIGHT  = LEFT_MARGIN + CELL_PITCH * (BITS_EIGHT + 1) + RIGHT_EIGHT;
   localparam int BYTES_FIVE   = (WIDTH_FIVE + 7) / 8;
   localparam int BYTES_EIGHT  = (WIDTH_EIGHT + 7) / 8;
   localparam int WORDS_FIVE   = (BYTES_FIVE + 7) / 8;
   localparam int WORDS_EIGHT  = (BYTES_EIGHT + 7) / 8;
   localparam int TAIL_FIVE    = BYTES_FIVE - 8 * (WORDS_FIVE - 1);
   localparam int TAIL_EIGHT   = BYTES_EIGHT - 8 * (WORDS_EIGHT - 1);

   localparam int WORD_BITS    = 64;
   localparam int WORDS_MAX    = 16;
   localparam int WIDX_W       = $clog2(WORDS_MAX);
   localparam int CNT_W        = 4;
   localparam int FULL_BYTES   = 8;

   localparam int CELL_W       = 4;
   localparam int CELLS        = 1 << CELL_W;
   localparam int CELL_SPROCKET = 3;
   localparam logic [CELL_W-1:0] CELL_NONE = '1;

   localparam int DX2_W        = 12;
   localparam int DY2_W        = 14;
   localparam int DLIM_W       = 11;
   localparam int SLIM_W       = 10;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_FIVE  = 1'b0;
   localparam logic MODE_EIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [6:0] row;
   } ptr_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] pixels;
      logic [CNT_W-1:0]     byte_count;
      logic                 last;
   } ptr_rsp_type;

   typedef struct packed {
      logic [CELLS-1:0]  cell_en;
      logic              data_ok;
      logic [DLIM_W-1:0] data_lim;
      logic              spr_ok;
      logic [SLIM_W-1:0] spr_lim;
      logic              mode;
   } ptr_job_type;

   typedef struct packed {
      logic [CELL_W-1:0] cidx;
      logic [DX2_W-1:0]  dx2;
   } px_info_type;

   typedef px_info_type [WORD_BITS-1:0] word_map_type;

   // entry j describes pixel x = w*64 + j
   function automatic word_map_type map_word(input int w);
      word_map_type m;
      int x;
      int rel;
      int cidx;
      int dx;
      for (int j = 0; j < WORD_BITS; j++) begin
         x = w * WORD_BITS + j;
         m[j].cidx = CELL_NONE;
         m[j].dx2  = '0;
         if (x >= LEFT_MARGIN) begin
            rel  = x - LEFT_MARGIN;
            cidx = rel / CELL_PITCH;
            dx   = (rel % CELL_PITCH) - HALF_PITCH;
            if (cidx < CELLS - 1) begin
               m[j].cidx = CELL_W'(cidx);
               m[j].dx2  = DX2_W'(dx * dx);
            end
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ptr_front.sv =====
// ----------------------------------------------------------------------------
// ptr_front
// Takes request beats and reduces each to a job: per-cell hole enables and
// the horizontal limits left over once the row's vertical offset is known.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ptr_pkg::ptr_req_type req_payload,
   input  logic                 tape_mode,
   input  logic                 q_full,
   output logic                 push,
   output ptr_pkg::ptr_job_type job
);
   import ptr_pkg::*;

   logic [6:0]       dy_abs;
   logic [DY2_W-1:0] dy_sq;

   always_comb begin
      if (req_payload.row >= 7'(HALF_PITCH)) begin
         dy_abs = req_payload.row - 7'(HALF_PITCH);
      end else begin
         dy_abs = 7'(HALF_PITCH) - req_payload.row;
      end
      dy_sq = DY2_W'(dy_abs) * DY2_W'(dy_abs);

      job.cell_en = '0;
      for (int c = 0; c < CELL_SPROCKET; c++) begin
         job.cell_en[c] = req_payload.frame_byte[c];
      end
      job.cell_en[CELL_SPROCKET] = 1'b1;
      for (int c = CELL_SPROCKET + 1; c <= BITS_EIGHT; c++) begin
         job.cell_en[c] = req_payload.frame_byte[c-1] &
                          ((tape_mode == MODE_EIGHT) || (c <= BITS_FIVE));
      end

      job.data_ok  = dy_sq <= DY2_W'(DATA_R2);
      job.data_lim = DLIM_W'(DY2_W'(DATA_R2) - dy_sq);
      job.spr_ok   = dy_sq <= DY2_W'(SPROCKET_R2);
      job.spr_lim  = SLIM_W'(DY2_W'(SPROCKET_R2) - dy_sq);
      job.mode     = tape_mode;
   end

   assign push      = req_valid && !q_full;
   assign req_stall = q_full;

endmodule

`default_nettype wire

// ===== hdl/ptr_queue.sv =====
// ----------------------------------------------------------------------------
// ptr_queue
// Short job FIFO between the front end and the word generator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ptr_pkg::ptr_job_type in_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 out_valid,
   output ptr_pkg::ptr_job_type out_job
);
   import ptr_pkg::*;

   ptr_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

   `PTR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `PTR_ASSERT_IMPLY(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `PTR_ASSERT_NEXT(a_count_up, clock, reset, push && !do_pop, count_ff == $past(count_ff) + 1'b1, "count did not rise on push")

endmodule

`default_nettype wire

// ===== hdl/ptr_back.sv =====
// ----------------------------------------------------------------------------
// ptr_back
// Word generator: walks the head job one 64-pixel word per beat into the
// output register, then retires it from the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ptr_pkg::ptr_job_type q_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ptr_pkg::ptr_rsp_type rsp_payload
);
   import ptr_pkg::*;

   word_map_type      map_tbl [WORDS_MAX];
   word_map_type      cur_map;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic [WIDX_W-1:0] last_idx;
   logic              is_last;
   logic              out_free;
   logic              advance;
   logic              rsp_valid_ff, rsp_valid_in;
   ptr_rsp_type       rsp_payload_ff, rsp_payload_in;
   logic              hit;

   for (genvar g = 0; g < WORDS_MAX; g++) begin : g_map
      assign map_tbl[g] = map_word(g);
   end

   assign cur_map  = map_tbl[word_ff];
   assign last_idx = (q_job.mode == MODE_EIGHT) ? WIDX_W'(WORDS_EIGHT - 1)
                                                : WIDX_W'(WORDS_FIVE - 1);
   assign is_last  = word_ff == last_idx;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = q_valid && out_free;
   assign pop      = advance && is_last;

   always_comb begin
      hit = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      word_in        = word_ff;
      if (out_free) begin
         rsp_valid_in = q_valid;
      end
      if (advance) begin
         word_in = is_last ? '0 : word_ff + 1'b1;
         for (int j = 0; j < WORD_BITS; j++) begin
            if (cur_map[j].cidx == CELL_W'(CELL_SPROCKET)) begin
               hit = q_job.spr_ok && (cur_map[j].dx2 <= DX2_W'(q_job.spr_lim));
            end else begin
               hit = q_job.data_ok && (cur_map[j].dx2 <= DX2_W'(q_job.data_lim));
            end
            rsp_payload_in.pixels[WORD_BITS-1-j] = hit && q_job.cell_en[cur_map[j].cidx];
         end
         rsp_payload_in.last = is_last;
         if (!is_last) begin
            rsp_payload_in.byte_count = CNT_W'(FULL_BYTES);
         end else if (q_job.mode == MODE_EIGHT) begin
            rsp_payload_in.byte_count = CNT_W'(TAIL_EIGHT);
         end else begin
            rsp_payload_in.byte_count = CNT_W'(TAIL_FIVE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `PTR_ASSERT_IMPLY(a_word_range, clock, reset, q_valid, word_ff <= last_idx, "word index past row end")
   `PTR_ASSERT_NEXT(a_word_wrap, clock, reset, pop, word_ff == '0, "word index not cleared after row")
   `PTR_ASSERT_IMPLY(a_full_word, clock, reset, rsp_valid_ff && !rsp_payload_ff.last, rsp_payload_ff.byte_count == CNT_W'(FULL_BYTES), "short word before row end")

endmodule

`default_nettype wire

// ===== hdl/punched_tape_row_rasterizer.sv =====
// ----------------------------------------------------------------------------
// punched_tape_row_rasterizer
// Rasterises one pixel row of a punched paper tape frame into 64-bit words.
// ----------------------------------------------------------------------------
// Each request beat (frame byte plus row 0..99 within the 100-pixel cell)
// yields one row of the tape image as MSB-first 64-bit words: 16 words for
// eight-level tape, 11 for five-level, the final word marked last and
// carrying its valid byte count. The word generator emits one word per cycle
// while rsp_stall is low, and successive rows follow with no gap; a
// two-entry job queue lets requests be taken while the current row streams
// out. An accepted request passes the job queue and then the output register.
// tape_mode (address 0, bit 0, resets to eight-level) should only be changed
// while no row is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module punched_tape_row_rasterizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ptr_pkg::ptr_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ptr_pkg::ptr_rsp_type rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import ptr_pkg::*;

   localparam logic REG_TAPE_MODE = 1'b0;

   logic        tape_mode_ff, tape_mode_in;
   logic        reg_idx;
   logic        push;
   logic        q_full;
   logic        q_valid;
   logic        pop;
   ptr_job_type front_job;
   ptr_job_type head_job;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      tape_mode_in = tape_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (reg_idx == REG_TAPE_MODE)) begin
         tape_mode_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (reg_idx == REG_TAPE_MODE) begin
         csr_prdata[0] = tape_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tape_mode_ff <= MODE_EIGHT;
      end else begin
         tape_mode_ff <= tape_mode_in;
      end
   end

   ptr_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .tape_mode   (tape_mode_ff),
      .q_full      (q_full),
      .push        (push),
      .job         (front_job)
   );

   ptr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_job    (front_job),
      .full      (q_full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_job   (head_job)
   );

   ptr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== bench/ptr_row_checker.sv =====
// ----------------------------------------------------------------------------
// ptr_row_checker
// Watches the request, result and register ports of the tape row rasteriser,
// works out every word of each accepted row from its own model of the tape
// geometry and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module ptr_row_checker #(
   parameter logic [2:0] MODE_ADDR = 3'd0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  ptr_pkg::ptr_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ptr_pkg::ptr_rsp_type rsp_payload,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   input  logic                 csr_pready,
   output int                   errors,
   output int                   words_due,
   output int                   rows_five,
   output int                   rows_eight,
   output int                   words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import ptr_pkg::*;

   localparam int PITCH         = 100;
   localparam int LEFT_PX       = 42;
   localparam int WIDTH_FIVE_PX  = 687;
   localparam int WIDTH_EIGHT_PX = 1000;
   localparam int HOLE_LIM      = 1296;
   localparam int SPROCKET_LIM  = 529;
   localparam int SPROCKET_CELL = 3;

   logic        eight_level;
   ptr_rsp_type row_words[$];
   int          n_fail = 0;
   int          n_five = 0;
   int          n_eight = 0;
   int          n_words = 0;

   function automatic bit hole_at(input int x, input logic eight, input logic [7:0] fb,
                                  input logic [6:0] r);
      int width;
      int nbits;
      int rel;
      int cidx;
      int dx;
      int dy;
      int d2;
      int bitn;
      width = eight ? WIDTH_EIGHT_PX : WIDTH_FIVE_PX;
      nbits = eight ? 8 : 5;
      if (x >= width || x < LEFT_PX) return 1'b0;
      rel  = x - LEFT_PX;
      cidx = rel / PITCH;
      if (cidx > nbits) return 1'b0;
      dx = (rel % PITCH) - PITCH / 2;
      dy = int'(r) - PITCH / 2;
      d2 = dx * dx + dy * dy;
      if (cidx == SPROCKET_CELL) return d2 <= SPROCKET_LIM;
      bitn = (cidx < SPROCKET_CELL) ? cidx : cidx - 1;
      if (!fb[bitn]) return 1'b0;
      return d2 <= HOLE_LIM;
   endfunction

   function automatic void raster_row(input logic [7:0] fb, input logic [6:0] r,
                                      input logic eight);
      int          width;
      int          nbytes;
      int          nwords;
      int          cnt;
      ptr_rsp_type w_exp;
      width  = eight ? WIDTH_EIGHT_PX : WIDTH_FIVE_PX;
      nbytes = (width + 7) / 8;
      nwords = (nbytes + 7) / 8;
      for (int w = 0; w < nwords; w++) begin
         cnt = nbytes - w * 8;
         if (cnt > 8) cnt = 8;
         w_exp.pixels = '0;
         for (int k = 0; k < 8; k++) begin
            for (int b = 0; b < 8; b++) begin
               if (k < cnt && hole_at((w * 8 + k) * 8 + b, eight, fb, r))
                  w_exp.pixels[63 - (k * 8 + b)] = 1'b1;
            end
         end
         w_exp.byte_count = 4'(cnt);
         w_exp.last       = (w == nwords - 1);
         row_words.push_back(w_exp);
      end
   endfunction

   always @(posedge clock) begin
      ptr_rsp_type want;
      if (reset) begin
         eight_level = MODE_EIGHT;
         row_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (row_words.size() == 0) begin
               $display("%0t: rsp beat with nothing due, actual %h", $time, rsp_payload);
               n_fail++;
            end else begin
               want = row_words.pop_front();
               n_words++;
               if (rsp_payload.pixels !== want.pixels) begin
                  $display("%0t: pixels expected %h actual %h", $time, want.pixels,
                           rsp_payload.pixels);
                  n_fail++;
               end
               if (rsp_payload.byte_count !== want.byte_count) begin
                  $display("%0t: byte_count expected %0d actual %0d", $time,
                           want.byte_count, rsp_payload.byte_count);
                  n_fail++;
               end
               if (rsp_payload.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last,
                           rsp_payload.last);
                  n_fail++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            raster_row(req_payload.frame_byte, req_payload.row, eight_level);
            if (eight_level == MODE_EIGHT) n_eight++;
            else n_five++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR)
            eight_level = csr_pwdata[0];
      end
      errors        <= n_fail;
      words_due     <= row_words.size();
      rows_five     <= n_five;
      rows_eight    <= n_eight;
      words_checked <= n_words;
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tape row rasteriser: a directed set of rows in
// both tape modes, then random rows in blocks with varying sender and receiver
// stalls and tape mode changes between blocks. Checking is done by the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptr_pkg::*;

   localparam logic [2:0] TAPE_MODE_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR     = 3'd4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ROWS = 320;
   localparam int BLOCKS      = 6;
   localparam int SETTLE      = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ptr_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   ptr_rsp_type rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors;
   int words_due;
   int rows_five;
   int rows_eight;
   int words_checked;
   int cycles = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;

   punched_tape_row_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ptr_row_checker #(.MODE_ADDR(TAPE_MODE_ADDR)) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .errors        (errors),
      .words_due     (words_due),
      .rows_five     (rows_five),
      .rows_eight    (rows_eight),
      .words_checked (words_checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles    <= cycles + 1;
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      if (cycles >= CYCLE_LIMIT) begin
         $display("punched_tape_row_rasterizer test failed");
         $finish;
      end
   end

   task automatic send_row(input logic [7:0] fb, input logic [6:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{frame_byte: fb, row: r};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // words_due is registered, so it lags the accepting edge
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input logic eight);
      logic [31:0] v;
      v    = $urandom();
      v[0] = eight;
      drain();
      write_csr(TAPE_MODE_ADDR, v);
   endtask

   initial begin
      logic [7:0] fb;
      logic [6:0] r;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // eight-level straight out of reset
      send_idle_pct = 32;
      rsp_idle_pct <= 80;
      send_row(8'hFF, 7'd50);
      send_row(8'h00, 7'd50);
      send_row(8'hFF, 7'd0);
      send_row(8'hFF, 7'd99);
      send_row(8'hFF, 7'd14);
      send_row(8'hFF, 7'd86);
      send_row(8'h01, 7'd27);
      send_row(8'h80, 7'd73);
      send_row(8'hAA, 7'd50);
      send_row(8'h55, 7'd50);
      send_row(8'hFF, 7'd100);
      send_row(8'hFF, 7'd127);

      // five-level, top bits must be ignored
      set_mode(MODE_FIVE);
      send_row(8'hFF, 7'd50);
      send_row(8'hE0, 7'd50);
      send_row(8'h1F, 7'd50);
      send_row(8'h15, 7'd40);
      send_row(8'h0A, 7'd64);
      send_row(8'h00, 7'd127);
      send_row(8'hFF, 7'd14);

      // write to an unmapped address leaves the mode alone
      drain();
      write_csr(SPARE_ADDR, 32'hFFFF_FFFF);
      send_row(8'hFF, 7'd50);

      for (int blk = 0; blk < BLOCKS; blk++) begin
         case (blk / 2)
            0: begin
               send_idle_pct = 32;
               rsp_idle_pct <= 80;
            end
            1: begin
               send_idle_pct = 80;
               rsp_idle_pct <= 32;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         set_mode((blk % 2) ? MODE_FIVE : MODE_EIGHT);
         for (int i = 0; i < RANDOM_ROWS / BLOCKS; i++) begin
            fb = 8'($urandom());
            r  = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100))
                                          : 7'($urandom_range(99));
            send_row(fb, r);
         end
      end
      drain();

      $display("rows checked: %0d five-level, %0d eight-level; words compared: %0d",
               rows_five, rows_eight, words_checked);
      $display("covered blank and full frames, hole edges, out-of-range rows, mode changes");
      if (errors == 0 && words_due == 0) begin
         $display("punched_tape_row_rasterizer test passed");
      end else begin
         $display("punched_tape_row_rasterizer test failed");
      end
      $finish;
   end

endmodule
